// ===== rtl/gtp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the greatest-ticks task picker.
// Depends on nothing; used by gtp_cell and greatest_ticks_task_picker.
package gtp_pkg;

    localparam int SLOT_W     = 4;
    localparam int PRIO_W     = 8;
    localparam int IN_TICK_W  = 8;
    localparam int OUT_TICK_W = 8;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_FLAG  = 2'd1;
    localparam logic [1:0] REQ_SCHED = 2'd2;

    typedef struct packed {
        logic wr;
        logic flag;
        logic reload;
        logic run;
    } gtp_cell_ctl_t;

endpackage

// ===== rtl/gtp_cell.sv =====
`timescale 1ns / 1ps
// One task slot of the picker chain: slot storage and one stage of the best-slot scan.
// Depends on gtp_pkg.
module gtp_cell import gtp_pkg::*; #(
    parameter int INDEX     = 0,
    parameter int IDX_W     = 4,
    parameter int TICK_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gtp_cell_ctl_t        ctl,
    input  logic [PRIO_W-1:0]    wr_prio,
    input  logic [TICK_BITS-1:0] wr_ticks,
    input  logic                 in_valid,
    input  logic                 in_hit,
    input  logic [TICK_BITS-1:0] in_best,
    input  logic [IDX_W-1:0]     in_pick,
    input  logic [PRIO_W-1:0]    in_prio,
    output logic                 out_valid,
    output logic                 out_hit,
    output logic [TICK_BITS-1:0] out_best,
    output logic [IDX_W-1:0]     out_pick,
    output logic [PRIO_W-1:0]    out_prio
);

    logic                 run_reg;
    logic [PRIO_W-1:0]    prio_reg;
    logic [TICK_BITS-1:0] ticks_reg;
    logic                 valid_reg;
    logic                 hit_reg;
    logic [TICK_BITS-1:0] best_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [PRIO_W-1:0]    tok_prio_reg;
    logic                 take;

    assign take = run_reg && (ticks_reg > in_best);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            prio_reg  <= '0;
            ticks_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
            if (ctl.wr) begin
                run_reg   <= ctl.run;
                prio_reg  <= wr_prio;
                ticks_reg <= wr_ticks;
            end else if (ctl.flag) begin
                run_reg <= ctl.run;
            end else if (ctl.reload && run_reg) begin
                ticks_reg <= TICK_BITS'(prio_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg      <= in_hit || take;
        best_reg     <= take ? ticks_reg : in_best;
        pick_reg     <= take ? IDX_W'(INDEX) : in_pick;
        tok_prio_reg <= take ? prio_reg : in_prio;
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;
    assign out_best  = best_reg;
    assign out_pick  = pick_reg;
    assign out_prio  = tok_prio_reg;

endmodule

// ===== rtl/greatest_ticks_task_picker.sv =====
`timescale 1ns / 1ps
// Top level of the greatest-ticks task picker: request sequencer, cell chain, result register.
// Depends on gtp_pkg and gtp_cell.
//
// Each input word on the s_ channel carries one request, its kind in s_tuser: write a whole
// task slot, change only a slot's runnable flag, or schedule. Every request returns exactly
// one word on the m_ channel with the current choice, its remaining ticks and the found and
// reloaded flags of a schedule.
// A write or flag change is answered in the cycle after it is taken. A schedule runs a scan
// token down the row of SLOTS cells, one cell per cycle; when no runnable slot has ticks left,
// the ticks are refilled from the priorities and the row scanned again. The length of the cell
// chain sets how long a schedule takes. One request is in work at a time. Writes and flag
// changes can be taken every cycle while the receiver keeps up; after a schedule the next word
// is taken only once the result is loaded. s_tready is high only between requests and while
// the result register is empty or being emptied, so a held result is never overwritten and
// holds off the next word.
// When the receiver stalls, the result word holds on m_tdata and a finished schedule waits
// for the register to free up.
// Reset clears every slot to not runnable with zero priority and ticks, and sets the choice
// to slot zero; no clearing pass is needed.
module greatest_ticks_task_picker import gtp_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int TICK_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[3:0], runnable_in[4], priority_in[12:5], ticks_in[20:13], zero[23:21]
    input  logic [23:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chosen_slot[3:0], found[4], reloaded[5], chosen_ticks[13:6], zero[15:14]
    output logic [15:0] m_tdata
);

    localparam int IDX_W = $clog2(SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN1  = 5'b00010,
        ST_RELOAD = 5'b00100,
        ST_SCAN2  = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]    in_slot;
    logic                 in_run;
    logic [PRIO_W-1:0]    in_prio;
    logic [TICK_BITS-1:0] in_ticks;
    logic                 accept;
    logic                 out_free;
    logic                 cur_hit;

    logic                 start_reg, start_next;
    logic [IDX_W-1:0]     choice_reg, choice_next;
    logic                 cur_run_reg, cur_run_next;
    logic [PRIO_W-1:0]    cur_prio_reg, cur_prio_next;
    logic [TICK_BITS-1:0] cur_ticks_reg, cur_ticks_next;
    logic                 res_found_reg, res_found_next;
    logic                 res_reloaded_reg, res_reloaded_next;
    logic                 m_valid_reg, m_valid_next;
    logic [15:0]          m_data_reg, m_data_next;
    logic                 load;

    logic                 ch_valid [SLOTS+1];
    logic                 ch_hit   [SLOTS+1];
    logic [TICK_BITS-1:0] ch_best  [SLOTS+1];
    logic [IDX_W-1:0]     ch_pick  [SLOTS+1];
    logic [PRIO_W-1:0]    ch_prio  [SLOTS+1];
    gtp_cell_ctl_t        cell_ctl [SLOTS];

    assign in_slot  = s_tdata[3:0];
    assign in_run   = s_tdata[4];
    assign in_prio  = s_tdata[12:5];
    assign in_ticks = TICK_BITS'(s_tdata[20:13]);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign cur_hit  = (32'(in_slot) == 32'(choice_reg));

    assign ch_valid[0] = start_reg;
    assign ch_hit[0]   = 1'b0;
    assign ch_best[0]  = '0;
    assign ch_pick[0]  = '0;
    assign ch_prio[0]  = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic slot_hit;
        assign slot_hit = (32'(in_slot) == i);
        assign cell_ctl[i].wr     = accept && (s_tuser == REQ_WRITE) && slot_hit;
        assign cell_ctl[i].flag   = accept && (s_tuser == REQ_FLAG) && slot_hit;
        assign cell_ctl[i].reload = (state_reg == ST_RELOAD);
        assign cell_ctl[i].run    = in_run;

        gtp_cell #(
            .INDEX     (i),
            .IDX_W     (IDX_W),
            .TICK_BITS (TICK_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (cell_ctl[i]),
            .wr_prio   (in_prio),
            .wr_ticks  (in_ticks),
            .in_valid  (ch_valid[i]),
            .in_hit    (ch_hit[i]),
            .in_best   (ch_best[i]),
            .in_pick   (ch_pick[i]),
            .in_prio   (ch_prio[i]),
            .out_valid (ch_valid[i+1]),
            .out_hit   (ch_hit[i+1]),
            .out_best  (ch_best[i+1]),
            .out_pick  (ch_pick[i+1]),
            .out_prio  (ch_prio[i+1])
        );
    end

    always_comb begin
        state_next        = state_reg;
        start_next        = 1'b0;
        choice_next       = choice_reg;
        cur_run_next      = cur_run_reg;
        cur_prio_next     = cur_prio_reg;
        cur_ticks_next    = cur_ticks_reg;
        res_found_next    = res_found_reg;
        res_reloaded_next = res_reloaded_reg;
        load              = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == REQ_SCHED) begin
                        state_next        = ST_SCAN1;
                        start_next        = 1'b1;
                        res_found_next    = 1'b0;
                        res_reloaded_next = 1'b0;
                    end else begin
                        load = 1'b1;
                        if (s_tuser == REQ_WRITE && cur_hit) begin
                            cur_run_next   = in_run;
                            cur_prio_next  = in_prio;
                            cur_ticks_next = in_ticks;
                        end else if (s_tuser == REQ_FLAG && cur_hit) begin
                            cur_run_next = in_run;
                        end
                    end
                end
            end
            ST_SCAN1, ST_SCAN2: begin
                if (ch_valid[SLOTS]) begin
                    if (ch_hit[SLOTS]) begin
                        state_next     = ST_RESP;
                        res_found_next = 1'b1;
                        choice_next    = ch_pick[SLOTS];
                        cur_run_next   = 1'b1;
                        cur_prio_next  = ch_prio[SLOTS];
                        cur_ticks_next = ch_best[SLOTS];
                    end else if (state_reg == ST_SCAN1) begin
                        state_next = ST_RELOAD;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RELOAD: begin
                state_next        = ST_SCAN2;
                start_next        = 1'b1;
                res_reloaded_next = 1'b1;
                if (cur_run_reg) begin
                    cur_ticks_next = TICK_BITS'(cur_prio_reg);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_data_next        = m_data_reg;
        if (load) begin
            m_data_next[3:0]  = SLOT_W'(choice_next);
            m_data_next[4]    = (state_reg == ST_RESP) && res_found_reg;
            m_data_next[5]    = (state_reg == ST_RESP) && res_reloaded_reg;
            m_data_next[13:6] = OUT_TICK_W'(cur_ticks_next);
            m_data_next[15:14] = 2'b00;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            start_reg        <= 1'b0;
            choice_reg       <= '0;
            cur_run_reg      <= 1'b0;
            cur_prio_reg     <= '0;
            cur_ticks_reg    <= '0;
            res_found_reg    <= 1'b0;
            res_reloaded_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            start_reg        <= start_next;
            choice_reg       <= choice_next;
            cur_run_reg      <= cur_run_next;
            cur_prio_reg     <= cur_prio_next;
            cur_ticks_reg    <= cur_ticks_next;
            res_found_reg    <= res_found_next;
            res_reloaded_reg <= res_reloaded_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_token_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ch_valid[SLOTS] |-> (state_reg == ST_SCAN1 || state_reg == ST_SCAN2))
        else $error("scan token left the chain outside a scan");

    a_start_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> (state_reg == ST_SCAN1 || state_reg == ST_SCAN2))
        else $error("scan started outside a scan state");

    a_found_has_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && res_found_reg) |-> (cur_ticks_reg != '0))
        else $error("schedule found a slot without remaining ticks");
`endif

endmodule

// ===== test/greatest_ticks_task_picker_check.sv =====
`timescale 1ns / 1ps
// Checker for the greatest-ticks task picker: watches the request and result channels,
// predicts every result word from its own copy of the task table and compares field by field.
// Depends on gtp_pkg; instantiated beside the block by greatest_ticks_task_picker_test.
module greatest_ticks_task_picker_check import gtp_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int TICK_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // slot[3:0], runnable_in[4], priority_in[12:5], ticks_in[20:13], zero[23:21]
    input  logic [23:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // chosen_slot[3:0], found[4], reloaded[5], chosen_ticks[13:6], zero[15:14]
    input  logic [15:0] m_tdata,
    output int          mismatches,
    output int          outstanding,
    output int          words_seen,
    output int          refills,
    output int          empty_picks
);

    typedef struct packed {
        logic [OUT_TICK_W-1:0] ticks;
        logic                  reloaded;
        logic                  found;
        logic [SLOT_W-1:0]     slot;
    } pick_t;

    logic                 run_tbl  [SLOTS];
    logic [PRIO_W-1:0]    prio_tbl [SLOTS];
    logic [TICK_BITS-1:0] tick_tbl [SLOTS];
    logic [SLOT_W-1:0]    choice;
    pick_t                choice_q [$];

    function automatic int best_slot();
        int                   pick;
        logic [TICK_BITS-1:0] best;
        pick = -1;
        best = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (run_tbl[i] && tick_tbl[i] > best) begin
                best = tick_tbl[i];
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic pick_t next_choice(input logic [1:0] req, input logic [SLOT_W-1:0] idx,
                                          input logic run, input logic [PRIO_W-1:0] prio,
                                          input logic [IN_TICK_W-1:0] tk);
        pick_t res;
        int    pick;
        res = '0;
        case (req)
            REQ_WRITE: begin
                if (idx < SLOTS) begin
                    run_tbl[idx]  = run;
                    prio_tbl[idx] = prio;
                    tick_tbl[idx] = TICK_BITS'(tk);
                end
            end
            REQ_FLAG: begin
                if (idx < SLOTS) begin
                    run_tbl[idx] = run;
                end
            end
            REQ_SCHED: begin
                pick = best_slot();
                if (pick < 0) begin
                    // Every runnable slot is out of ticks, so refill them and look again.
                    for (int i = 0; i < SLOTS; i++) begin
                        if (run_tbl[i]) begin
                            tick_tbl[i] = TICK_BITS'(prio_tbl[i]);
                        end
                    end
                    res.reloaded = 1'b1;
                    pick = best_slot();
                end
                if (pick >= 0) begin
                    choice    = SLOT_W'(pick);
                    res.found = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (choice >= SLOTS) begin
            choice = '0;
        end
        res.slot  = choice;
        res.ticks = OUT_TICK_W'(tick_tbl[choice]);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        pick_t got;
        pick_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                run_tbl[i]  = 1'b0;
                prio_tbl[i] = '0;
                tick_tbl[i] = '0;
            end
            choice = '0;
            choice_q.delete();
            mismatches  = 0;
            words_seen  = 0;
            refills     = 0;
            empty_picks = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                got = pick_t'(m_tdata[13:0]);
                if (choice_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result word %h with no request waiting, expected none",
                             $time, m_tdata);
                end else begin
                    want = choice_q.pop_front();
                    check_field("chosen_slot", 16'(want.slot), 16'(got.slot));
                    check_field("found", 16'(want.found), 16'(got.found));
                    check_field("reloaded", 16'(want.reloaded), 16'(got.reloaded));
                    check_field("chosen_ticks", 16'(want.ticks), 16'(got.ticks));
                    check_field("padding", 16'h0000, 16'(m_tdata[15:14]));
                end
            end
            if (s_tvalid && s_tready) begin
                want = next_choice(s_tuser, s_tdata[3:0], s_tdata[4], s_tdata[12:5],
                                   s_tdata[20:13]);
                choice_q.push_back(want);
                if (s_tuser == REQ_SCHED) begin
                    if (want.reloaded) begin
                        refills++;
                    end
                    if (!want.found) begin
                        empty_picks++;
                    end
                end
            end
        end
        outstanding = choice_q.size();
    end

endmodule

// ===== test/greatest_ticks_task_picker_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the greatest-ticks task picker: clock, reset, request stimulus in bursts,
// a stalling receiver and the verdict. Depends on gtp_pkg, the block and its checker module.
module greatest_ticks_task_picker_test import gtp_pkg::*;;

    localparam logic [1:0] REQ_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         PHASES      = 10;
    localparam int         PHASE_ITEMS = 125;

    localparam int RX_OPEN     = 0;
    localparam int RX_LIGHT    = 1;
    localparam int RX_HEAVY    = 2;
    localparam int RX_PERIODIC = 3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // slot[3:0], runnable_in[4], priority_in[12:5], ticks_in[20:13], zero[23:21]
    logic [23:0] s_tdata;
    // req_type[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // chosen_slot[3:0], found[4], reloaded[5], chosen_ticks[13:6], zero[15:14]
    logic [15:0] m_tdata;

    int mismatches;
    int outstanding;
    int words_seen;
    int refills;
    int empty_picks;

    int   cycles = 0;
    int   items_sent;
    int   burst_left;
    int   gap_max;
    int   holds_asked = 0;
    int   holds_done  = 0;
    int   stall_mode  = RX_OPEN;
    int   mode_left   = 0;
    int   rx_tick     = 0;

    greatest_ticks_task_picker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    greatest_ticks_task_picker_check checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .words_seen  (words_seen),
        .refills     (refills),
        .empty_picks (empty_picks)
    );

    initial begin
        aclk = 1'b0;
    end

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver switches between its own stall patterns and honors long hold-off requests.
    always begin
        @(posedge aclk);
        if (holds_done < holds_asked) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            holds_done++;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
                mode_left  = $urandom_range(50, 300);
            end
            mode_left--;
            rx_tick++;
            case (stall_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    task automatic offer(input logic [1:0] req, input logic [3:0] slot, input logic run,
                         input logic [7:0] prio, input logic [7:0] tk);
        s_tuser  <= req;
        s_tdata  <= {3'b000, tk, prio, run, slot};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0 && gap_max > 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
    endtask

    initial begin
        int         slot_hi;
        int         pick;
        logic [1:0] req;
        logic [7:0] prio;
        logic [7:0] tk;

        items_sent   = 0;
        burst_left   = 4;
        gap_max      = 6;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_WRITE;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: nothing to run, the refill changes nothing and slot zero stays.
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        offer(REQ_WRITE, 4'd0, 1'b1, 8'd0, 8'd0);
        offer(REQ_WRITE, 4'd15, 1'b1, 8'd255, 8'd255);
        offer(REQ_WRITE, 4'd5, 1'b1, 8'd10, 8'd255);
        // A tie on the most ticks goes to the lower slot.
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        offer(REQ_FLAG, 4'd5, 1'b0, 8'd0, 8'd0);
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        // The unused request type with every bit set changes nothing.
        offer(REQ_SPARE, 4'd15, 1'b1, 8'd255, 8'd255);
        // Writing the chosen slot shows its new ticks right away.
        offer(REQ_WRITE, 4'd15, 1'b1, 8'd255, 8'd0);
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        offer(REQ_WRITE, 4'd15, 1'b1, 8'd0, 8'd0);
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        offer(REQ_WRITE, 4'd7, 1'b0, 8'd200, 8'd1);
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        offer(REQ_FLAG, 4'd7, 1'b1, 8'd255, 8'd255);
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        offer(REQ_WRITE, 4'd3, 1'b1, 8'haa, 8'h55);
        offer(REQ_WRITE, 4'd12, 1'b0, 8'h55, 8'haa);
        offer(REQ_WRITE, 4'd10, 1'b1, 8'h01, 8'h00);
        offer(REQ_FLAG, 4'd7, 1'b0, 8'd0, 8'd0);
        offer(REQ_FLAG, 4'd3, 1'b0, 8'd0, 8'd0);
        offer(REQ_FLAG, 4'd15, 1'b0, 8'd0, 8'd0);
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        offer(REQ_SCHED, 4'd0, 1'b0, 8'd0, 8'd0);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            slot_hi = (phase % 3 == 1) ? 3 : 15;
            gap_max = (phase % 4 == 3) ? 0 : 12;
            if (phase == 2 || phase == 6) begin
                holds_asked++;
            end
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                req  = (pick < 38) ? REQ_WRITE : (pick < 58) ? REQ_FLAG :
                       (pick < 95) ? REQ_SCHED : REQ_SPARE;
                pick = $urandom_range(0, 9);
                prio = (pick < 2) ? 8'd0 : (pick == 2) ? 8'd255 : 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                tk   = (pick < 4) ? 8'd0 : (pick == 4) ? 8'd255 : 8'($urandom_range(0, 255));
                offer(req, 4'($urandom_range(0, slot_hi)), ($urandom_range(0, 3) != 0),
                      prio, tk);
            end
            if (phase % 2 == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        $display("Sent %0d requests and checked %0d result words, %0d long receiver hold-offs.",
                 items_sent, words_seen, holds_done);
        $display("Schedules that refilled ticks first: %0d, schedules that found nothing: %0d.",
                 refills, empty_picks);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
